// ===== rtl/clr_pkg.sv =====
`default_nettype none

package clr_pkg;

	localparam int DEF_COORD_BITS = 14;
	localparam int DEF_ADDR_BITS  = 24;
	localparam int CFG_W          = 13;
	localparam int COLOR_W        = 32;

	localparam logic [CFG_W-1:0] WIDTH_RESET  = CFG_W'(1920);
	localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(1080);

	localparam logic KIND_START   = 1'b0;
	localparam logic KIND_ADVANCE = 1'b1;

	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

endpackage

`default_nettype wire

// ===== rtl/clr_cmd_if.sv =====
`default_nettype none

interface clr_cmd_if
	import clr_pkg::*;
#(
	parameter int COORD_BITS = DEF_COORD_BITS
);
	logic                         valid;
	logic                         ready;
	logic                         kind;
	logic signed [COORD_BITS-1:0] start_x;
	logic signed [COORD_BITS-1:0] start_y;
	logic signed [COORD_BITS-1:0] end_x;
	logic signed [COORD_BITS-1:0] end_y;
	logic        [COLOR_W-1:0]    line_color;

	modport source (
		output valid, kind, start_x, start_y, end_x, end_y, line_color,
		input  ready
	);

	modport sink (
		input  valid, kind, start_x, start_y, end_x, end_y, line_color,
		output ready
	);
endinterface

`default_nettype wire

// ===== rtl/clr_pix_if.sv =====
`default_nettype none

interface clr_pix_if
	import clr_pkg::*;
#(
	parameter int COORD_BITS = DEF_COORD_BITS,
	parameter int ADDR_BITS  = DEF_ADDR_BITS
);
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] pixel_x;
	logic signed [COORD_BITS-1:0] pixel_y;
	logic        [ADDR_BITS-1:0]  pixel_address;
	logic        [COLOR_W-1:0]    pixel_color;
	logic                         visible;
	logic                         last;

	modport source (
		output valid, pixel_x, pixel_y, pixel_address, pixel_color, visible, last,
		input  ready
	);

	modport sink (
		input  valid, pixel_x, pixel_y, pixel_address, pixel_color, visible, last,
		output ready
	);
endinterface

`default_nettype wire

// ===== rtl/clipped_line_rasterizer.sv =====
`default_nettype none

// Bresenham line generator. A start request loads both endpoints and the colour
// and yields the first pixel; each advance request yields the next pixel, and an
// advance after the final endpoint yields nothing. A request is taken whenever
// stage one is empty or moves on. The first register stage holds the line state
// and the stepped coordinates, the second holds the screen test and the
// row-times-width address product. With the pixel side ready the block
// sustains one request and one pixel per clock. Pixels outside the configured
// screen carry visible low and a zero address. Write the screen size only
// while no line is in progress and the pipeline is empty.
module clipped_line_rasterizer
	import clr_pkg::*;
#(
	parameter int COORD_BITS = DEF_COORD_BITS,
	parameter int ADDR_BITS  = DEF_ADDR_BITS
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	clr_cmd_if.sink               cmd,
	clr_pix_if.source             pix,
	input  wire logic             wr_en,
	input  wire logic             wr_index,
	input  wire logic [CFG_W-1:0] wr_data
);

	localparam int DELTA_W = COORD_BITS + 1;
	localparam int ERR_W   = COORD_BITS + 2;
	localparam int E2_W    = ERR_W + 1;

	logic [CFG_W-1:0] width_q;
	logic [CFG_W-1:0] height_q;

	logic signed [COORD_BITS-1:0] cur_x_q, cur_y_q, tgt_x_q, tgt_y_q;
	logic        [DELTA_W-1:0]    dx_q, dy_q;
	logic                         neg_x_q, neg_y_q;
	logic signed [ERR_W-1:0]      err_q;
	logic        [COLOR_W-1:0]    color_q;
	logic                         active_q;

	logic signed [COORD_BITS-1:0] cur_x_n, cur_y_n, tgt_x_n, tgt_y_n;
	logic        [DELTA_W-1:0]    dx_n, dy_n;
	logic                         neg_x_n, neg_y_n;
	logic signed [ERR_W-1:0]      err_n;
	logic        [COLOR_W-1:0]    color_n;
	logic                         done_n;
	logic                         emit;

	logic signed [DELTA_W-1:0]    diff_x, diff_y;
	logic signed [E2_W-1:0]       e2, dx_e, dy_e;
	logic signed [ERR_W-1:0]      dx_err, dy_err;
	logic                         step_x, step_y;

	logic                         valid_s1;
	logic signed [COORD_BITS-1:0] x_s1, y_s1;
	logic        [COLOR_W-1:0]    color_s1;
	logic                         last_s1;

	logic                         valid_s2;
	logic signed [COORD_BITS-1:0] x_s2, y_s2;
	logic        [ADDR_BITS-1:0]  addr_s2;
	logic        [COLOR_W-1:0]    color_s2;
	logic                         vis_s2;
	logic                         last_s2;

	logic                         ready_s1, ready_s2, accept;
	logic                         vis_c;
	logic        [ADDR_BITS-1:0]  addr_c;

	assign ready_s2  = !valid_s2 || pix.ready;
	assign ready_s1  = !valid_s1 || ready_s2;
	assign cmd.ready = ready_s1;
	assign accept    = cmd.valid && ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_WIDTH:  width_q  <= wr_data;
				REG_HEIGHT: height_q <= wr_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		diff_x = $signed({cmd.end_x[COORD_BITS-1], cmd.end_x})
			- $signed({cmd.start_x[COORD_BITS-1], cmd.start_x});
		diff_y = $signed({cmd.end_y[COORD_BITS-1], cmd.end_y})
			- $signed({cmd.start_y[COORD_BITS-1], cmd.start_y});
		e2     = $signed({err_q, 1'b0});
		dx_e   = $signed(E2_W'(dx_q));
		dy_e   = $signed(E2_W'(dy_q));
		dx_err = $signed(ERR_W'(dx_q));
		dy_err = $signed(ERR_W'(dy_q));
		step_x = e2 > -dy_e;
		step_y = e2 < dx_e;

		cur_x_n = cur_x_q;
		cur_y_n = cur_y_q;
		tgt_x_n = tgt_x_q;
		tgt_y_n = tgt_y_q;
		dx_n    = dx_q;
		dy_n    = dy_q;
		neg_x_n = neg_x_q;
		neg_y_n = neg_y_q;
		err_n   = err_q;
		color_n = color_q;
		emit    = 1'b0;

		if (cmd.kind == KIND_START) begin
			cur_x_n = cmd.start_x;
			cur_y_n = cmd.start_y;
			tgt_x_n = cmd.end_x;
			tgt_y_n = cmd.end_y;
			dx_n    = diff_x[DELTA_W-1] ? DELTA_W'(-diff_x) : DELTA_W'(diff_x);
			dy_n    = diff_y[DELTA_W-1] ? DELTA_W'(-diff_y) : DELTA_W'(diff_y);
			neg_x_n = diff_x[DELTA_W-1] || (diff_x == '0);
			neg_y_n = diff_y[DELTA_W-1] || (diff_y == '0);
			err_n   = $signed(ERR_W'(dx_n)) - $signed(ERR_W'(dy_n));
			color_n = cmd.line_color;
			emit    = 1'b1;
		end else if (active_q) begin
			if (step_x) begin
				cur_x_n = neg_x_q ? cur_x_q - COORD_BITS'(1) : cur_x_q + COORD_BITS'(1);
			end
			if (step_y) begin
				cur_y_n = neg_y_q ? cur_y_q - COORD_BITS'(1) : cur_y_q + COORD_BITS'(1);
			end
			err_n = err_q - (step_x ? dy_err : '0) + (step_y ? dx_err : '0);
			emit  = 1'b1;
		end

		done_n = (cur_x_n == tgt_x_n) && (cur_y_n == tgt_y_n);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q  <= '0;
			cur_y_q  <= '0;
			tgt_x_q  <= '0;
			tgt_y_q  <= '0;
			dx_q     <= '0;
			dy_q     <= '0;
			neg_x_q  <= 1'b0;
			neg_y_q  <= 1'b0;
			err_q    <= '0;
			color_q  <= '0;
			active_q <= 1'b0;
		end else if (accept && emit) begin
			cur_x_q  <= cur_x_n;
			cur_y_q  <= cur_y_n;
			tgt_x_q  <= tgt_x_n;
			tgt_y_q  <= tgt_y_n;
			dx_q     <= dx_n;
			dy_q     <= dy_n;
			neg_x_q  <= neg_x_n;
			neg_y_q  <= neg_y_n;
			err_q    <= err_n;
			color_q  <= color_n;
			active_q <= !done_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			valid_s1 <= accept && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && emit) begin
			x_s1     <= cur_x_n;
			y_s1     <= cur_y_n;
			color_s1 <= color_n;
			last_s1  <= done_n;
		end
	end

	clr_addr #(
		.COORD_BITS (COORD_BITS),
		.ADDR_BITS  (ADDR_BITS)
	) u_addr (
		.x          (x_s1),
		.y          (y_s1),
		.width_cfg  (width_q),
		.height_cfg (height_q),
		.visible    (vis_c),
		.address    (addr_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && ready_s2) begin
			x_s2     <= x_s1;
			y_s2     <= y_s1;
			addr_s2  <= addr_c;
			color_s2 <= color_s1;
			vis_s2   <= vis_c;
			last_s2  <= last_s1;
		end
	end

	assign pix.valid         = valid_s2;
	assign pix.pixel_x       = x_s2;
	assign pix.pixel_y       = y_s2;
	assign pix.pixel_address = addr_s2;
	assign pix.pixel_color   = color_s2;
	assign pix.visible       = vis_s2;
	assign pix.last          = last_s2;

	// advance with no line in progress: drop
	a_idle_advance_drops: assert property (@(posedge clk) disable iff (!arst_n)
		accept && cmd.kind == KIND_ADVANCE && !active_q |=> !valid_s1)
		else $error("advance while idle produced a pixel");

	a_start_emits: assert property (@(posedge clk) disable iff (!arst_n)
		accept && cmd.kind == KIND_START |=> valid_s1)
		else $error("start request produced no pixel");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !ready_s2 |=> valid_s1 && $stable(x_s1) && $stable(y_s1)
			&& $stable(last_s1))
		else $error("stage one changed while stalled");

	a_active_fall: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(active_q) |-> $past(accept) && valid_s1 && last_s1)
		else $error("line ended without its final pixel");

endmodule

`default_nettype wire

// ===== rtl/clr_addr.sv =====
`default_nettype none

module clr_addr
	import clr_pkg::*;
#(
	parameter int COORD_BITS = DEF_COORD_BITS,
	parameter int ADDR_BITS  = DEF_ADDR_BITS
) (
	input  wire logic signed [COORD_BITS-1:0] x,
	input  wire logic signed [COORD_BITS-1:0] y,
	input  wire logic        [CFG_W-1:0]      width_cfg,
	input  wire logic        [CFG_W-1:0]      height_cfg,
	output logic                              visible,
	output logic             [ADDR_BITS-1:0]  address
);

	localparam int MAG_W  = COORD_BITS - 1;
	localparam int CMP_W  = (MAG_W > CFG_W) ? MAG_W : CFG_W;
	localparam int PROD_W = MAG_W + CFG_W;
	localparam int SUM_W  = (PROD_W + 1 > ADDR_BITS) ? PROD_W + 1 : ADDR_BITS;

	logic              x_ok;
	logic              y_ok;
	logic [PROD_W-1:0] prod;
	logic [SUM_W-1:0]  sum;

	always_comb begin
		x_ok = !x[COORD_BITS-1] && (CMP_W'(x[MAG_W-1:0]) < CMP_W'(width_cfg));
		y_ok = !y[COORD_BITS-1] && (CMP_W'(y[MAG_W-1:0]) < CMP_W'(height_cfg));
		prod = PROD_W'(y[MAG_W-1:0]) * PROD_W'(width_cfg);
		sum  = SUM_W'(prod) + SUM_W'(x[MAG_W-1:0]);
		visible = x_ok && y_ok;
		address = visible ? sum[ADDR_BITS-1:0] : '0;
	end

endmodule

`default_nettype wire
